// File: rtl/bpp_pkg.sv
// Shared constants for the Boris particle push pipeline.
package bpp_pkg;

    // Default number formats
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    // Latency of one fixed-point multiply unit
    localparam int MUL_LAT = 2;

    // Configuration register indexes
    typedef logic [2:0] t_cfg_index;
    localparam t_cfg_index CFG_TIME_STEP      = 3'd0;
    localparam t_cfg_index CFG_MAGNETIC_BZ    = 3'd1;
    localparam t_cfg_index CFG_TRAP_STIFFNESS = 3'd2;
    localparam t_cfg_index CFG_TRAP_CENTER_XY = 3'd3;
    localparam t_cfg_index CFG_DAMPING_FACTOR = 3'd4;
    localparam t_cfg_index CFG_RESTITUTION    = 3'd5;
    localparam t_cfg_index CFG_BOX_WIDTH      = 3'd6;
    localparam t_cfg_index CFG_BOX_HEIGHT     = 3'd7;

    // Reset value of the two unity factors (1.0 in Q16.16)
    localparam logic [16:0] UNITY_FACTOR_RST = 17'h10000;

endpackage

// File: rtl/bpp_delay.sv
// Enabled shift line that carries side data alongside a pipelined unit.
module bpp_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_d
);
    import bpp_pkg::*;

    logic [WIDTH-1:0] r_line [DEPTH];

    // Advance the line on every pipeline step
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_d = r_line[DEPTH-1];

endmodule

// File: rtl/bpp_mul.sv
// Two-stage saturating fixed-point multiply, magnitude truncated.
module bpp_mul #(
    parameter int FRAC_BITS = bpp_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = bpp_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [WORD_BITS-1:0] i_a,
    input  logic signed [WORD_BITS-1:0] i_b,
    output logic signed [WORD_BITS-1:0] o_p
);
    import bpp_pkg::*;

    localparam int PW = 2 * WORD_BITS;
    localparam logic [PW-1:0] LIM_POS = (PW'(1) << (WORD_BITS - 1)) - PW'(1);
    localparam logic [PW-1:0] LIM_NEG = PW'(1) << (WORD_BITS - 1);
    localparam logic [WORD_BITS-1:0] WMAX_W = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WMIN_W = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic [WORD_BITS-1:0] mag_a, mag_b;
    logic [PW-1:0]        r_prod;
    logic                 r_neg;
    logic [PW-1:0]        shifted;
    logic [WORD_BITS-1:0] n_p;
    logic signed [WORD_BITS-1:0] r_p;

    // Take magnitudes; the most negative word maps to 2^(W-1)
    assign mag_a = i_a[WORD_BITS-1] ? WORD_BITS'(~i_a + WORD_BITS'(1)) : i_a;
    assign mag_b = i_b[WORD_BITS-1] ? WORD_BITS'(~i_b + WORD_BITS'(1)) : i_b;

    // Stage one: raw magnitude product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PW'(mag_a) * PW'(mag_b);
            r_neg  <= i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1];
        end
    end

    // Stage two: drop fraction bits, saturate, restore sign
    always_comb begin
        shifted = r_prod >> FRAC_BITS;
        if (r_neg) begin
            if (shifted > LIM_NEG) n_p = WMIN_W;
            else                   n_p = WORD_BITS'(~shifted[WORD_BITS-1:0] + WORD_BITS'(1));
        end else begin
            if (shifted > LIM_POS) n_p = WMAX_W;
            else                   n_p = shifted[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// File: rtl/bpp_div.sv
// Pipelined restoring divider, one quotient bit per stage, for (a << F) / d.
module bpp_div #(
    parameter int FRAC_BITS = bpp_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = bpp_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [WORD_BITS-1:0] i_a,
    input  logic signed [WORD_BITS-1:0] i_d,
    output logic signed [WORD_BITS-1:0] o_q
);
    import bpp_pkg::*;

    localparam int N = WORD_BITS + FRAC_BITS;
    localparam logic [N-1:0] LIM_POS = (N'(1) << (WORD_BITS - 1)) - N'(1);
    localparam logic [N-1:0] LIM_NEG = N'(1) << (WORD_BITS - 1);
    localparam logic [WORD_BITS-1:0] WMAX_W = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WMIN_W = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic [WORD_BITS-1:0] mag_a;
    logic [WORD_BITS-2:0] r_rem  [N];
    logic [N-1:0]         r_num  [N];
    logic [N-1:0]         r_quo  [N];
    logic [WORD_BITS-2:0] r_den  [N];
    logic                 r_neg  [N];
    logic                 r_zero [N];
    logic [WORD_BITS-1:0] n_q;
    logic signed [WORD_BITS-1:0] r_q;

    assign mag_a = i_a[WORD_BITS-1] ? WORD_BITS'(~i_a + WORD_BITS'(1)) : i_a;

    // One quotient bit per stage
    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [WORD_BITS-2:0] p_rem, p_den;
        logic [N-1:0]         p_num, p_quo;
        logic                 p_neg, p_zero;
        logic [WORD_BITS-1:0] rem_sh;
        logic                 ge;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_num  = {mag_a, {FRAC_BITS{1'b0}}};
            assign p_quo  = '0;
            assign p_den  = i_d[WORD_BITS-2:0];
            assign p_neg  = i_a[WORD_BITS-1];
            assign p_zero = i_d[WORD_BITS-1] || (i_d == '0);
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_num  = r_num[k-1];
            assign p_quo  = r_quo[k-1];
            assign p_den  = r_den[k-1];
            assign p_neg  = r_neg[k-1];
            assign p_zero = r_zero[k-1];
        end

        assign rem_sh = {p_rem, p_num[N-1]};
        assign ge     = rem_sh >= {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? (WORD_BITS-1)'(rem_sh - {1'b0, p_den})
                                : rem_sh[WORD_BITS-2:0];
                r_num[k]  <= p_num << 1;
                r_quo[k]  <= {p_quo[N-2:0], ge};
                r_den[k]  <= p_den;
                r_neg[k]  <= p_neg;
                r_zero[k] <= p_zero;
            end
        end
    end

    // Saturate the full quotient and restore the sign; a non-positive divisor gives zero
    always_comb begin
        if (r_zero[N-1]) begin
            n_q = '0;
        end else if (r_neg[N-1]) begin
            if (r_quo[N-1] > LIM_NEG) n_q = WMIN_W;
            else n_q = WORD_BITS'(~r_quo[N-1][WORD_BITS-1:0] + WORD_BITS'(1));
        end else begin
            if (r_quo[N-1] > LIM_POS) n_q = WMAX_W;
            else n_q = r_quo[N-1][WORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// File: rtl/boris_particle_push.sv
// Top level of the pipelined Boris particle push with wall reflection.
//
// Input channel i_valid/o_ready moves one particle (position, velocity,
// radius, charge, mass, local electric field) per transfer; output channel
// o_valid/i_ready moves the updated position and velocity.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data, one
// register per cycle; the user must write only while no particle is in
// flight, and the block itself does not enforce it. Throughput: one
// particle per cycle while the receiver takes results. Two pipelined
// dividers run in series (charge/mass, then the Boris rotation factor),
// each giving one quotient bit per stage. Defaults: Q16.16, 32-bit words.
// Reset clears every valid bit and loads the register defaults (dt, field,
// trap and box zero; damping and restitution 1.0).
// When the receiver stalls with a result shown, the whole pipeline holds
// and o_ready drops; nothing is lost or repeated.
module boris_particle_push #(
    parameter int FRAC_BITS = bpp_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = bpp_pkg::WORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  bpp_pkg::t_cfg_index     i_cfg_index,
    input  logic [63:0]             i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [31:0]      i_pos_x,
    input  logic signed [31:0]      i_pos_y,
    input  logic signed [31:0]      i_vel_x,
    input  logic signed [31:0]      i_vel_y,
    input  logic [30:0]             i_radius,
    input  logic signed [31:0]      i_charge,
    input  logic [30:0]             i_mass,
    input  logic signed [31:0]      i_field_x,
    input  logic signed [31:0]      i_field_y,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [31:0]      o_new_pos_x,
    output logic signed [31:0]      o_new_pos_y,
    output logic signed [31:0]      o_new_vel_x,
    output logic signed [31:0]      o_new_vel_y
);
    import bpp_pkg::*;

    localparam int W = WORD_BITS;
    localparam int DIV_LAT = WORD_BITS + FRAC_BITS + 1;
    localparam int VLEN = 2 * DIV_LAT + 7 * MUL_LAT + 7;
    localparam logic signed [63:0] WMAX_L = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] WMIN_L = -WMAX_L - 64'sd1;
    localparam logic [W-1:0] WMAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN_W = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE_W = W'(64'sd1 <<< FRAC_BITS);

    // Saturate a wide value into the working word
    function automatic logic signed [W-1:0] fit_w(input logic signed [63:0] v);
        logic signed [W-1:0] res;
        if (v > WMAX_L)      res = WMAX_W;
        else if (v < WMIN_L) res = WMIN_W;
        else                 res = v[W-1:0];
        return res;
    endfunction

    function automatic logic signed [W-1:0] add_s(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? WMIN_W : WMAX_W;
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sub_s(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? WMIN_W : WMAX_W;
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] neg_s(input logic signed [W-1:0] a);
        logic signed [W-1:0] res;
        if (a == WMIN_W) res = WMAX_W;
        else             res = W'(-a);
        return res;
    endfunction

    function automatic logic [31:0] out32(input logic signed [W-1:0] v);
        logic signed [63:0] e;
        logic [31:0] res;
        e = 64'(v);
        if (e > 64'sd2147483647)       res = 32'h7fffffff;
        else if (e < -64'sd2147483648) res = 32'h80000000;
        else                           res = e[31:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    logic [30:0] r_time_step, r_trap_stiffness, r_box_width, r_box_height;
    logic [31:0] r_magnetic_bz;
    logic [63:0] r_trap_center_xy;
    logic [16:0] r_damping_factor, r_restitution;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step      <= '0;
            r_magnetic_bz    <= '0;
            r_trap_stiffness <= '0;
            r_trap_center_xy <= '0;
            r_damping_factor <= UNITY_FACTOR_RST;
            r_restitution    <= UNITY_FACTOR_RST;
            r_box_width      <= '0;
            r_box_height     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TIME_STEP:      r_time_step      <= i_cfg_data[30:0];
                CFG_MAGNETIC_BZ:    r_magnetic_bz    <= i_cfg_data[31:0];
                CFG_TRAP_STIFFNESS: r_trap_stiffness <= i_cfg_data[30:0];
                CFG_TRAP_CENTER_XY: r_trap_center_xy <= i_cfg_data;
                CFG_DAMPING_FACTOR: r_damping_factor <= i_cfg_data[16:0];
                CFG_RESTITUTION:    r_restitution    <= i_cfg_data[16:0];
                CFG_BOX_WIDTH:      r_box_width      <= i_cfg_data[30:0];
                CFG_BOX_HEIGHT:     r_box_height     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Working-word views of the registers (static while particles fly)
    logic signed [W-1:0] dt_w, hdt_w, bz_w, k_w, cx_w, cy_w, damp_w, rs_w, bw_w, bh_w;
    logic                trap_on, box_on;

    assign dt_w    = fit_w(signed'({33'd0, r_time_step}));
    assign hdt_w   = dt_w >>> 1;
    assign bz_w    = fit_w(64'(signed'(r_magnetic_bz)));
    assign k_w     = fit_w(signed'({33'd0, r_trap_stiffness}));
    assign cx_w    = fit_w(64'(signed'(r_trap_center_xy[31:0])));
    assign cy_w    = fit_w(64'(signed'(r_trap_center_xy[63:32])));
    assign damp_w  = fit_w(signed'({47'd0, r_damping_factor}));
    assign rs_w    = fit_w(signed'({47'd0, r_restitution}));
    assign bw_w    = fit_w(signed'({33'd0, r_box_width}));
    assign bh_w    = fit_w(signed'({33'd0, r_box_height}));
    assign trap_on = r_trap_stiffness != '0;
    assign box_on  = r_box_width != '0;

    // ------------------------------------------------------------------
    // Pipeline advance and valid bits
    logic            en;
    logic [VLEN-1:0] r_vld;
    logic            r_o_valid;

    assign en      = !r_o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[VLEN-2:0], i_valid};
            r_o_valid <= r_vld[VLEN-1];
        end
    end

    // ------------------------------------------------------------------
    // Input stage: saturate the fields into the working word
    logic signed [W-1:0] r0_px, r0_py, r0_vx, r0_vy, r0_rad, r0_chg, r0_ms, r0_ex, r0_ey;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_px  <= fit_w(64'(i_pos_x));
            r0_py  <= fit_w(64'(i_pos_y));
            r0_vx  <= fit_w(64'(i_vel_x));
            r0_vy  <= fit_w(64'(i_vel_y));
            r0_rad <= fit_w(signed'({33'd0, i_radius}));
            r0_chg <= fit_w(64'(i_charge));
            r0_ms  <= fit_w(signed'({33'd0, i_mass}));
            r0_ex  <= fit_w(64'(i_field_x));
            r0_ey  <= fit_w(64'(i_field_y));
        end
    end

    // ------------------------------------------------------------------
    // Charge over mass and trap constant over mass
    logic signed [W-1:0] a_qm, a_km;
    logic signed [W-1:0] a1_px, a1_py, a1_vx, a1_vy, a1_rad, a1_ex, a1_ey, a1_dx, a1_dy;

    bpp_div #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_div_qm (
        .i_clk(i_clk), .i_en(en), .i_a(r0_chg), .i_d(r0_ms), .o_q(a_qm));
    bpp_div #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_div_km (
        .i_clk(i_clk), .i_en(en), .i_a(k_w), .i_d(r0_ms), .o_q(a_km));

    bpp_delay #(.WIDTH(9 * W), .DEPTH(DIV_LAT)) u_dl_a (
        .i_clk(i_clk), .i_en(en),
        .i_d({r0_px, r0_py, r0_vx, r0_vy, r0_rad, r0_ex, r0_ey,
              sub_s(r0_px, cx_w), sub_s(r0_py, cy_w)}),
        .o_d({a1_px, a1_py, a1_vx, a1_vy, a1_rad, a1_ex, a1_ey, a1_dx, a1_dy}));

    // ------------------------------------------------------------------
    // Half-step factor and trap spring force
    logic signed [W-1:0] b_a, b_kdx, b_kdy;
    logic signed [W-1:0] b_px, b_py, b_vx, b_vy, b_rad, b_ex, b_ey;

    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_a (
        .i_clk(i_clk), .i_en(en), .i_a(a_qm), .i_b(hdt_w), .o_p(b_a));
    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_kdx (
        .i_clk(i_clk), .i_en(en), .i_a(a_km), .i_b(a1_dx), .o_p(b_kdx));
    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_kdy (
        .i_clk(i_clk), .i_en(en), .i_a(a_km), .i_b(a1_dy), .o_p(b_kdy));

    bpp_delay #(.WIDTH(7 * W), .DEPTH(MUL_LAT)) u_dl_b (
        .i_clk(i_clk), .i_en(en),
        .i_d({a1_px, a1_py, a1_vx, a1_vy, a1_rad, a1_ex, a1_ey}),
        .o_d({b_px, b_py, b_vx, b_vy, b_rad, b_ex, b_ey}));

    // ------------------------------------------------------------------
    // Electric kick, rotation vector and trap velocity change
    logic signed [W-1:0] c_kx, c_ky, c_tz, c_tx, c_ty;
    logic signed [W-1:0] c_px, c_py, c_vx, c_vy, c_rad;

    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_kx (
        .i_clk(i_clk), .i_en(en), .i_a(b_a), .i_b(b_ex), .o_p(c_kx));
    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_ky (
        .i_clk(i_clk), .i_en(en), .i_a(b_a), .i_b(b_ey), .o_p(c_ky));
    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_tz (
        .i_clk(i_clk), .i_en(en), .i_a(b_a), .i_b(bz_w), .o_p(c_tz));
    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_tx (
        .i_clk(i_clk), .i_en(en), .i_a(neg_s(b_kdx)), .i_b(dt_w), .o_p(c_tx));
    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_ty (
        .i_clk(i_clk), .i_en(en), .i_a(neg_s(b_kdy)), .i_b(dt_w), .o_p(c_ty));

    bpp_delay #(.WIDTH(5 * W), .DEPTH(MUL_LAT)) u_dl_c (
        .i_clk(i_clk), .i_en(en),
        .i_d({b_px, b_py, b_vx, b_vy, b_rad}),
        .o_d({c_px, c_py, c_vx, c_vy, c_rad}));

    // ------------------------------------------------------------------
    // First half-kick
    logic signed [W-1:0] r_d_vx1, r_d_vy1, r_d_px, r_d_py, r_d_rad;
    logic signed [W-1:0] r_d_kx, r_d_ky, r_d_tz, r_d_tx, r_d_ty;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_vx1 <= add_s(c_vx, c_kx);
            r_d_vy1 <= add_s(c_vy, c_ky);
            r_d_px  <= c_px;
            r_d_py  <= c_py;
            r_d_rad <= c_rad;
            r_d_kx  <= c_kx;
            r_d_ky  <= c_ky;
            r_d_tz  <= c_tz;
            r_d_tx  <= c_tx;
            r_d_ty  <= c_ty;
        end
    end

    // ------------------------------------------------------------------
    // Rotation cross terms and tz squared
    logic signed [W-1:0] e_p, e_q, e_tt;
    logic signed [W-1:0] e_px, e_py, e_rad, e_kx, e_ky, e_tz, e_tx, e_ty, e_vx1, e_vy1;

    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_p (
        .i_clk(i_clk), .i_en(en), .i_a(r_d_vy1), .i_b(r_d_tz), .o_p(e_p));
    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_q (
        .i_clk(i_clk), .i_en(en), .i_a(r_d_vx1), .i_b(r_d_tz), .o_p(e_q));
    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_tt (
        .i_clk(i_clk), .i_en(en), .i_a(r_d_tz), .i_b(r_d_tz), .o_p(e_tt));

    bpp_delay #(.WIDTH(10 * W), .DEPTH(MUL_LAT)) u_dl_e (
        .i_clk(i_clk), .i_en(en),
        .i_d({r_d_px, r_d_py, r_d_rad, r_d_kx, r_d_ky, r_d_tz, r_d_tx, r_d_ty,
              r_d_vx1, r_d_vy1}),
        .o_d({e_px, e_py, e_rad, e_kx, e_ky, e_tz, e_tx, e_ty, e_vx1, e_vy1}));

    // ------------------------------------------------------------------
    // Half-rotated velocity and rotation factor operands
    logic signed [W-1:0] r_f_wx, r_f_wy, r_f_num, r_f_den;
    logic signed [W-1:0] r_f_px, r_f_py, r_f_rad, r_f_kx, r_f_ky, r_f_tx, r_f_ty;
    logic signed [W-1:0] r_f_vx1, r_f_vy1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_wx  <= add_s(e_vx1, e_p);
            r_f_wy  <= sub_s(e_vy1, e_q);
            r_f_num <= add_s(e_tz, e_tz);
            r_f_den <= add_s(ONE_W, e_tt);
            r_f_px  <= e_px;
            r_f_py  <= e_py;
            r_f_rad <= e_rad;
            r_f_kx  <= e_kx;
            r_f_ky  <= e_ky;
            r_f_tx  <= e_tx;
            r_f_ty  <= e_ty;
            r_f_vx1 <= e_vx1;
            r_f_vy1 <= e_vy1;
        end
    end

    // ------------------------------------------------------------------
    // Rotation factor s = 2 tz / (1 + tz^2)
    logic signed [W-1:0] g_s;
    logic signed [W-1:0] g_px, g_py, g_rad, g_kx, g_ky, g_tx, g_ty, g_vx1, g_vy1, g_wx, g_wy;

    bpp_div #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_div_s (
        .i_clk(i_clk), .i_en(en), .i_a(r_f_num), .i_d(r_f_den), .o_q(g_s));

    bpp_delay #(.WIDTH(11 * W), .DEPTH(DIV_LAT)) u_dl_g (
        .i_clk(i_clk), .i_en(en),
        .i_d({r_f_px, r_f_py, r_f_rad, r_f_kx, r_f_ky, r_f_tx, r_f_ty,
              r_f_vx1, r_f_vy1, r_f_wx, r_f_wy}),
        .o_d({g_px, g_py, g_rad, g_kx, g_ky, g_tx, g_ty, g_vx1, g_vy1, g_wx, g_wy}));

    // ------------------------------------------------------------------
    // Second rotation cross terms
    logic signed [W-1:0] h_m1, h_m2;
    logic signed [W-1:0] h_px, h_py, h_rad, h_kx, h_ky, h_tx, h_ty, h_vx1, h_vy1;

    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_m1 (
        .i_clk(i_clk), .i_en(en), .i_a(g_wy), .i_b(g_s), .o_p(h_m1));
    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_m2 (
        .i_clk(i_clk), .i_en(en), .i_a(g_wx), .i_b(g_s), .o_p(h_m2));

    bpp_delay #(.WIDTH(9 * W), .DEPTH(MUL_LAT)) u_dl_h (
        .i_clk(i_clk), .i_en(en),
        .i_d({g_px, g_py, g_rad, g_kx, g_ky, g_tx, g_ty, g_vx1, g_vy1}),
        .o_d({h_px, h_py, h_rad, h_kx, h_ky, h_tx, h_ty, h_vx1, h_vy1}));

    // ------------------------------------------------------------------
    // Close the rotation, second half-kick, trap pull
    logic signed [W-1:0] r_i_fx, r_i_fy, r_i_px, r_i_py, r_i_rad;
    logic signed [W-1:0] r_i_kx, r_i_ky, r_i_tx, r_i_ty;
    logic signed [W-1:0] r_j_fx, r_j_fy, r_j_px, r_j_py, r_j_rad, r_j_tx, r_j_ty;
    logic signed [W-1:0] r_k_fx, r_k_fy, r_k_px, r_k_py, r_k_rad;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_fx  <= add_s(h_vx1, h_m1);
            r_i_fy  <= sub_s(h_vy1, h_m2);
            r_i_px  <= h_px;
            r_i_py  <= h_py;
            r_i_rad <= h_rad;
            r_i_kx  <= h_kx;
            r_i_ky  <= h_ky;
            r_i_tx  <= h_tx;
            r_i_ty  <= h_ty;

            r_j_fx  <= add_s(r_i_fx, r_i_kx);
            r_j_fy  <= add_s(r_i_fy, r_i_ky);
            r_j_px  <= r_i_px;
            r_j_py  <= r_i_py;
            r_j_rad <= r_i_rad;
            r_j_tx  <= r_i_tx;
            r_j_ty  <= r_i_ty;

            r_k_fx  <= trap_on ? add_s(r_j_fx, r_j_tx) : r_j_fx;
            r_k_fy  <= trap_on ? add_s(r_j_fy, r_j_ty) : r_j_fy;
            r_k_px  <= r_j_px;
            r_k_py  <= r_j_py;
            r_k_rad <= r_j_rad;
        end
    end

    // ------------------------------------------------------------------
    // Damping
    logic signed [W-1:0] l_fx, l_fy, l_px, l_py, l_rad;

    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_dx (
        .i_clk(i_clk), .i_en(en), .i_a(r_k_fx), .i_b(damp_w), .o_p(l_fx));
    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_dy (
        .i_clk(i_clk), .i_en(en), .i_a(r_k_fy), .i_b(damp_w), .o_p(l_fy));

    bpp_delay #(.WIDTH(3 * W), .DEPTH(MUL_LAT)) u_dl_l (
        .i_clk(i_clk), .i_en(en),
        .i_d({r_k_px, r_k_py, r_k_rad}),
        .o_d({l_px, l_py, l_rad}));

    // ------------------------------------------------------------------
    // Displacement over the step
    logic signed [W-1:0] m_dx, m_dy, m_px, m_py, m_rad, m_fx, m_fy;

    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_sx (
        .i_clk(i_clk), .i_en(en), .i_a(l_fx), .i_b(dt_w), .o_p(m_dx));
    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_sy (
        .i_clk(i_clk), .i_en(en), .i_a(l_fy), .i_b(dt_w), .o_p(m_dy));

    bpp_delay #(.WIDTH(5 * W), .DEPTH(MUL_LAT)) u_dl_m (
        .i_clk(i_clk), .i_en(en),
        .i_d({l_px, l_py, l_rad, l_fx, l_fy}),
        .o_d({m_px, m_py, m_rad, m_fx, m_fy}));

    // ------------------------------------------------------------------
    // New position and upper wall limits
    logic signed [W-1:0] r_n_px, r_n_py, r_n_hx, r_n_hy, r_n_rad, r_n_fx, r_n_fy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_px  <= add_s(m_px, m_dx);
            r_n_py  <= add_s(m_py, m_dy);
            r_n_hx  <= sub_s(bw_w, m_rad);
            r_n_hy  <= sub_s(bh_w, m_rad);
            r_n_rad <= m_rad;
            r_n_fx  <= m_fx;
            r_n_fy  <= m_fy;
        end
    end

    // ------------------------------------------------------------------
    // Wall contact: clamp position, bounce velocity with restitution
    logic                lo_x, hi_x, lo_y, hi_y, cl_x, cl_y;
    logic signed [W-1:0] pc_x, pc_y;
    logic signed [W-1:0] o_bx, o_by, o_px, o_py, o_fx, o_fy;
    logic                o_clx, o_cly;

    assign lo_x = r_n_px < r_n_rad;
    assign hi_x = r_n_px > r_n_hx;
    assign lo_y = r_n_py < r_n_rad;
    assign hi_y = r_n_py > r_n_hy;
    assign cl_x = box_on && (lo_x || hi_x);
    assign cl_y = box_on && (lo_y || hi_y);
    assign pc_x = !box_on ? r_n_px : (lo_x ? r_n_rad : (hi_x ? r_n_hx : r_n_px));
    assign pc_y = !box_on ? r_n_py : (lo_y ? r_n_rad : (hi_y ? r_n_hy : r_n_py));

    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_bx (
        .i_clk(i_clk), .i_en(en), .i_a(neg_s(r_n_fx)), .i_b(rs_w), .o_p(o_bx));
    bpp_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul_by (
        .i_clk(i_clk), .i_en(en), .i_a(neg_s(r_n_fy)), .i_b(rs_w), .o_p(o_by));

    bpp_delay #(.WIDTH(4 * W + 2), .DEPTH(MUL_LAT)) u_dl_o (
        .i_clk(i_clk), .i_en(en),
        .i_d({pc_x, pc_y, r_n_fx, r_n_fy, cl_x, cl_y}),
        .o_d({o_px, o_py, o_fx, o_fy, o_clx, o_cly}));

    // ------------------------------------------------------------------
    // Output register: hold while the receiver stalls
    logic [31:0] r_o_px, r_o_py, r_o_vx, r_o_vy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_px <= out32(o_px);
            r_o_py <= out32(o_py);
            r_o_vx <= out32(o_clx ? o_bx : o_fx);
            r_o_vy <= out32(o_cly ? o_by : o_fy);
        end
    end

    assign o_valid     = r_o_valid;
    assign o_new_pos_x = r_o_px;
    assign o_new_pos_y = r_o_py;
    assign o_new_vel_x = r_o_vx;
    assign o_new_vel_y = r_o_vy;

    // ------------------------------------------------------------------
    // Checks
    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_result_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_vld[VLEN-1]))
        else $error("result shown without an item at the pipeline end");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && (r_vld == '0))
        else $error("reset left a valid bit set");

endmodule
